### hdl/smd_pkg.sv
package smd_pkg;

    localparam logic [1:0] OP_ARITH     = 2'd2;

    localparam logic [5:0] OP3_FLUSH    = 6'h3b;
    localparam logic [5:0] MULDIV_MASK  = 6'h2a;
    localparam logic [5:0] MULDIV_MATCH = 6'h0a;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FLUSH   = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    localparam int DIV_STEPS = 32;

    // per-item payload carried down the pipe
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  rd;
        logic        ok;
        logic        sgn;
        logic        div;
        logic        cc;
        logic        negq;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] prod;
        logic [31:0] res;
        logic [31:0] chk;
    } pl_t;

    function automatic logic [31:0] neg32(input logic [31:0] v);
        neg32 = 32'd0 - v;
    endfunction

endpackage

### hdl/smd_ifs.sv
interface smd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] first_source;
    logic [31:0] second_source;
    modport source (output valid, instruction, first_source, second_source, input ready);
    modport sink (input valid, instruction, first_source, second_source, output ready);
endinterface

interface smd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  dest_index;
    logic        dest_write;
    logic [31:0] result_value;
    logic [7:0]  flags_value;
    logic        flags_write;
    modport source (output valid, status, dest_index, dest_write, result_value,
                    flags_value, flags_write, input ready);
    modport sink (input valid, status, dest_index, dest_write, result_value,
                  flags_value, flags_write, output ready);
endinterface

### hdl/sparc_mul_div_execute_core.sv
// Throughput: one word per cycle while the output word is taken (the pipe
// holds otherwise); the 32-stage restoring divider is fully pipelined (one
// quotient bit per stage) and shared by divides and by the multiply overflow
// check, so every stage takes a new word each cycle that the pipe advances.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
module sparc_mul_div_execute_core (
    input  logic         clk,
    input  logic         rst_n,
    smd_in_if.sink       in_ch,
    smd_out_if.source    out_ch
);

    localparam int NS = smd_pkg::DIV_STEPS;

    // whole pipe moves together; holds when the output word is not taken
    logic adv;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // ---------------- stage 1: decode ----------------
    smd_pkg::pl_t d_next;
    always_comb
    begin
        logic [31:0] w;
        logic        ibit;
        logic [5:0]  op3;
        w = in_ch.instruction;
        op3 = w[24:19];
        ibit = w[13];
        d_next = '0;
        d_next.rd = w[29:25];
        d_next.a = (w[18:14] == 5'd0) ? 32'd0 : in_ch.first_source;
        if (ibit)
        begin
            d_next.b = {{19{w[12]}}, w[12:0]};
        end
        else
        begin
            d_next.b = (w[4:0] == 5'd0) ? 32'd0 : in_ch.second_source;
        end
        d_next.sgn = op3[0];
        d_next.div = op3[2];
        d_next.cc = op3[4];
        if (w[31:30] != smd_pkg::OP_ARITH || (!ibit && w[12:5] != 8'd0))
        begin
            d_next.status = smd_pkg::ST_ILLEGAL;
        end
        else if (op3 == smd_pkg::OP3_FLUSH)
        begin
            d_next.status = smd_pkg::ST_FLUSH;
        end
        else if ((op3 & smd_pkg::MULDIV_MASK) != smd_pkg::MULDIV_MATCH)
        begin
            d_next.status = smd_pkg::ST_ILLEGAL;
        end
        else if (op3[2] && d_next.b == 32'd0)
        begin
            d_next.status = smd_pkg::ST_DIVZERO;
        end
        else
        begin
            d_next.status = smd_pkg::ST_DONE;
            d_next.ok = 1'b1;
        end
    end

    smd_pkg::pl_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // ---------------- stage 2: product ----------------
    smd_pkg::pl_t s2_next;
    always_comb
    begin
        s2_next = s1_reg;
        s2_next.prod = s1_reg.a * s1_reg.b;
    end

    // ---------------- stage 3: divider operands ----------------
    // divides use a / b; multiplies divide the product back by b for V
    smd_pkg::pl_t s3_next;
    logic [31:0]  dvd_next, dvs_next;
    always_comb
    begin
        logic [31:0] n;
        n = s2_reg.div ? s2_reg.a : s2_reg.prod;
        s3_next = s2_reg;
        s3_next.negq = s2_reg.sgn && (n[31] ^ s2_reg.b[31]);
        dvd_next = (s2_reg.sgn && n[31]) ? smd_pkg::neg32(n) : n;
        dvs_next = (s2_reg.sgn && s2_reg.b[31]) ? smd_pkg::neg32(s2_reg.b) : s2_reg.b;
    end

    logic [31:0] dvs_reg [NS+1];
    logic [63:0] rq_reg [NS+1];
    smd_pkg::pl_t dp_reg [NS+1];
    logic        dv_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= d_next;
            s2_reg <= s2_next;
            dp_reg[0] <= s3_next;
            dvs_reg[0] <= dvs_next;
            rq_reg[0] <= {32'd0, dvd_next};
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar i = 0; i < NS; i++)
    begin : g_div
        logic [64:0] t;
        logic [32:0] top;
        logic        ge;
        logic [63:0] rq_next;
        always_comb
        begin
            t = {rq_reg[i], 1'b0};
            top = t[64:32];
            ge = top >= {1'b0, dvs_reg[i]};
            if (ge)
            begin
                top = top - {1'b0, dvs_reg[i]};
            end
            rq_next = {top[31:0], t[31:1], ge};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rq_reg[i+1] <= rq_next;
                dvs_reg[i+1] <= dvs_reg[i];
                dp_reg[i+1] <= dp_reg[i];
            end
        end
    end

    // ---------------- stage 4: signed quotient, result select ----------------
    smd_pkg::pl_t s4_next;
    always_comb
    begin
        logic [31:0] q;
        q = rq_reg[NS][31:0];
        s4_next = dp_reg[NS];
        s4_next.chk = dp_reg[NS].negq ? smd_pkg::neg32(q) : q;
        s4_next.res = dp_reg[NS].div ? s4_next.chk : dp_reg[NS].prod;
    end

    // ---------------- stage 5: divide check product ----------------
    // for divides chk becomes res * b; for multiplies chk keeps the quotient
    smd_pkg::pl_t s5_next;
    always_comb
    begin
        s5_next = s4_reg;
        if (s4_reg.div)
        begin
            s5_next.chk = s4_reg.res * s4_reg.b;
        end
    end

    // ---------------- stage 6: flags, output register ----------------
    logic [3:0] nzv;
    always_comb
    begin
        nzv = 4'd0;
        if (s5_reg.res == 32'd0)
        begin
            nzv[2] = 1'b1;
        end
        else
        begin
            nzv[3] = s5_reg.sgn && s5_reg.res[31];
            if (s5_reg.div)
            begin
                nzv[1] = s5_reg.chk != s5_reg.a;
            end
            else
            begin
                nzv[1] = (s5_reg.b != 32'd0) && (s5_reg.chk != s5_reg.a);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= dv_reg[NS];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s4_next;
            s4_reg <= s3_reg;
            s5_reg <= s5_next;
            out_ch.status <= s5_reg.status;
            out_ch.dest_index <= s5_reg.rd;
            out_ch.dest_write <= s5_reg.ok && (s5_reg.rd != 5'd0);
            out_ch.result_value <= s5_reg.ok ? s5_reg.res : 32'd0;
            out_ch.flags_value <= (s5_reg.ok && s5_reg.cc) ? {nzv, nzv} : 8'd0;
            out_ch.flags_write <= s5_reg.ok && s5_reg.cc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.valid <= 1'b0;
        end
        else if (adv)
        begin
            out_ch.valid <= v5_reg;
        end
    end

endmodule

### verif/tb_sparc_mul_div_execute_core.sv
`timescale 1ns / 100ps

module tb_sparc_mul_div_execute_core;

    // one expected result word
    typedef struct {
        logic [1:0]  status;
        logic [4:0]  dest_index;
        logic        dest_write;
        logic [31:0] result_value;
        logic [7:0]  flags_value;
        logic        flags_write;
    } muldiv_result_t;

    // Instruction result tracker: predicts each accepted instruction word and
    // checks result words in order against the predictions.
    class muldiv_tracker;
        muldiv_result_t pending[$];
        int errors;
        int checked;
        int status_seen[4];

        static function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? 32'd0 - a : a;
            mb = b[31] ? 32'd0 - b : b;
            if (mb == 32'd0)
                return 32'd0;
            q = ma / mb;
            return (a[31] != b[31]) ? 32'd0 - q : q;
        endfunction

        static function logic [31:0] udiv(logic [31:0] a, logic [31:0] b);
            return (b == 32'd0) ? 32'd0 : a / b;
        endfunction

        function void note_instruction(logic [31:0] w, logic [31:0] s1, logic [31:0] s2);
            muldiv_result_t r;
            logic [5:0]  op3;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] res;
            logic [31:0] back;
            logic [3:0]  nzv;
            logic        sgn;
            logic        dv;
            logic        cc;
            op3 = w[24:19];
            a = (w[18:14] == 5'd0) ? 32'd0 : s1;
            if (w[13])
                b = {{19{w[12]}}, w[12:0]};
            else
                b = (w[4:0] == 5'd0) ? 32'd0 : s2;
            r.status = smd_pkg::ST_DONE;
            r.dest_index = w[29:25];
            r.dest_write = 1'b0;
            r.result_value = '0;
            r.flags_value = '0;
            r.flags_write = 1'b0;
            if (w[31:30] != smd_pkg::OP_ARITH || (!w[13] && w[12:5] != 8'd0))
                r.status = smd_pkg::ST_ILLEGAL;
            else if (op3 == smd_pkg::OP3_FLUSH)
                r.status = smd_pkg::ST_FLUSH;
            else if ((op3 & smd_pkg::MULDIV_MASK) != smd_pkg::MULDIV_MATCH)
                r.status = smd_pkg::ST_ILLEGAL;
            else begin
                sgn = op3[0];
                dv = op3[2];
                cc = op3[4];
                if (dv && b == 32'd0)
                    r.status = smd_pkg::ST_DIVZERO;
                else begin
                    if (dv)
                        res = sgn ? sdiv(a, b) : udiv(a, b);
                    else
                        res = a * b;
                    if (cc) begin
                        nzv = 4'd0;
                        if (res == 32'd0)
                            nzv = 4'b0100;
                        else begin
                            if (sgn && res[31])
                                nzv[3] = 1'b1;
                            if (dv) begin
                                if (res * b != a)
                                    nzv[1] = 1'b1;
                            end
                            else if (b != 32'd0) begin
                                back = sgn ? sdiv(res, b) : udiv(res, b);
                                if (back != a)
                                    nzv[1] = 1'b1;
                            end
                        end
                        r.flags_value = {nzv, nzv};
                        r.flags_write = 1'b1;
                    end
                    r.result_value = res;
                    r.dest_write = (w[29:25] != 5'd0);
                end
            end
            pending.push_back(r);
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH word %0d %s: got %h expected %h", checked, what, got, want);
            errors++;
        endfunction

        function void check_result(muldiv_result_t g);
            muldiv_result_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result word", 32'd0, 32'd0);
                checked++;
                return;
            end
            e = pending.pop_front();
            status_seen[e.status]++;
            if (g.status !== e.status)
                report_mismatch("status", 32'(g.status), 32'(e.status));
            if (g.dest_index !== e.dest_index)
                report_mismatch("dest_index", 32'(g.dest_index), 32'(e.dest_index));
            if (g.dest_write !== e.dest_write)
                report_mismatch("dest_write", 32'(g.dest_write), 32'(e.dest_write));
            if (g.result_value !== e.result_value)
                report_mismatch("result_value", g.result_value, e.result_value);
            if (g.flags_value !== e.flags_value)
                report_mismatch("flags_value", 32'(g.flags_value), 32'(e.flags_value));
            if (g.flags_write !== e.flags_write)
                report_mismatch("flags_write", 32'(g.flags_write), 32'(e.flags_write));
            checked++;
        endfunction
    endclass

    // op3 codes of the multiply/divide group
    localparam logic [5:0] OP3_UMUL   = 6'h0a;
    localparam logic [5:0] OP3_SMUL   = 6'h0b;
    localparam logic [5:0] OP3_UDIV   = 6'h0e;
    localparam logic [5:0] OP3_SDIV   = 6'h0f;
    localparam logic [5:0] OP3_UMULCC = 6'h1a;
    localparam logic [5:0] OP3_SMULCC = 6'h1b;
    localparam logic [5:0] OP3_UDIVCC = 6'h1e;
    localparam logic [5:0] OP3_SDIVCC = 6'h1f;
    localparam int         LATENCY    = 38;
    localparam int         RANDOM_WORDS = 1130;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smd_in_if  in_ch ();
    smd_out_if out_ch ();

    sparc_mul_div_execute_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    muldiv_tracker tracker = new();
    bit   quiet_tail;     // no idling on either side near the end
    bit   hold_sink;      // long receiver stall, driven by its own process
    int   sent;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.instruction = '0;
        in_ch.first_source = '0;
        in_ch.second_source = '0;
        out_ch.ready = 1'b0;
    end

    // Note accepted words and check results at the rising edge.
    always @(posedge clk)
    begin
        muldiv_result_t g;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_instruction(in_ch.instruction, in_ch.first_source,
                                         in_ch.second_source);
            if (out_ch.valid && out_ch.ready) begin
                g.status = out_ch.status;
                g.dest_index = out_ch.dest_index;
                g.dest_write = out_ch.dest_write;
                g.result_value = out_ch.result_value;
                g.flags_value = out_ch.flags_value;
                g.flags_write = out_ch.flags_write;
                tracker.check_result(g);
            end
        end
    end

    // Receiver: ready drops in random bursts, or for a long stretch on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                gap = $urandom_range(1, 4);
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Drive one word; holds until accepted, sometimes after a random idle burst.
    task automatic send_word(logic [31:0] w, logic [31:0] s1, logic [31:0] s2);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.instruction <= w;
        in_ch.first_source <= s1;
        in_ch.second_source <= s2;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic [31:0] reg_form(logic [4:0] rd, logic [5:0] op3,
                                             logic [4:0] rs1, logic [4:0] rs2);
        return {smd_pkg::OP_ARITH, rd, op3, rs1, 1'b0, 8'd0, rs2};
    endfunction

    function automatic logic [31:0] imm_form(logic [4:0] rd, logic [5:0] op3,
                                             logic [4:0] rs1, logic [12:0] simm);
        return {smd_pkg::OP_ARITH, rd, op3, rs1, 1'b1, simm};
    endfunction

    function automatic logic [5:0] pick_muldiv();
        logic [5:0] ops[8];
        ops = '{OP3_UMUL, OP3_SMUL, OP3_UDIV, OP3_SDIV,
                OP3_UMULCC, OP3_SMULCC, OP3_UDIVCC, OP3_SDIVCC};
        return ops[$urandom_range(0, 7)];
    endfunction

    // Operand values weighted toward the edges: zero, one, -1, signed limits.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int wait_cycles;
        logic [5:0] op3;
        logic [31:0] w;
        quiet_tail = 1'b0;
        hold_sink = 1'b0;
        sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, register-zero sources, edge operands.
        send_word(reg_form(5'd1, OP3_UMUL, 5'd1, 5'd2), 32'hffff_ffff, 32'hffff_ffff);
        send_word(reg_form(5'd2, OP3_SMUL, 5'd1, 5'd2), 32'h8000_0000, 32'hffff_ffff);
        send_word(reg_form(5'd3, OP3_UMULCC, 5'd1, 5'd2), 32'h0001_0000, 32'h0001_0000);
        send_word(reg_form(5'd4, OP3_SMULCC, 5'd1, 5'd2), 32'hffff_fffe, 32'd3);
        send_word(reg_form(5'd5, OP3_UDIV, 5'd1, 5'd2), 32'hffff_ffff, 32'd7);
        send_word(reg_form(5'd6, OP3_SDIV, 5'd1, 5'd2), 32'hffff_fff9, 32'd2);
        // most negative over -1 wraps
        send_word(reg_form(5'd7, OP3_SDIVCC, 5'd1, 5'd2), 32'h8000_0000, 32'hffff_ffff);
        send_word(reg_form(5'd8, OP3_UDIVCC, 5'd1, 5'd2), 32'd10, 32'd3);
        // divide by zero, register and via rs2 field zero
        send_word(reg_form(5'd9, OP3_UDIV, 5'd1, 5'd2), 32'd5, 32'd0);
        send_word(reg_form(5'd10, OP3_SDIVCC, 5'd1, 5'd0), 32'd5, 32'd9);
        // rs1 field zero reads as zero; rd zero suppresses the write
        send_word(reg_form(5'd0, OP3_UMULCC, 5'd0, 5'd2), 32'hdead_beef, 32'd3);
        send_word(imm_form(5'd31, OP3_SMULCC, 5'd31, 13'h1000), 32'h7fff_ffff, 32'd0);
        send_word(imm_form(5'd11, OP3_SDIV, 5'd3, 13'h1fff), 32'h8000_0000, 32'd0);
        send_word(imm_form(5'd12, OP3_UDIVCC, 5'd3, 13'h0fff), 32'hffff_ffff, 32'd0);
        send_word(imm_form(5'd13, OP3_UDIV, 5'd3, 13'h0000), 32'd1, 32'd0);
        send_word(imm_form(5'd14, smd_pkg::OP3_FLUSH, 5'd3, 13'h0005), 32'd1, 32'd2);
        send_word(reg_form(5'd15, smd_pkg::OP3_FLUSH, 5'd3, 5'd4), 32'd1, 32'd2);
        // register form with nonzero asi, even on a flush
        send_word({smd_pkg::OP_ARITH, 5'd16, smd_pkg::OP3_FLUSH, 5'd1, 1'b0, 8'hff, 5'd2},
                  32'd1, 32'd2);
        send_word({smd_pkg::OP_ARITH, 5'd17, OP3_UMUL, 5'd1, 1'b0, 8'h01, 5'd2},
                  32'd1, 32'd2);
        // wrong format and unsupported op3
        send_word({2'd0, 5'd18, OP3_UMUL, 5'd1, 1'b0, 8'd0, 5'd2}, 32'd3, 32'd4);
        send_word({2'd3, 5'd19, OP3_SMUL, 5'd1, 1'b1, 13'd4}, 32'd3, 32'd4);
        send_word(reg_form(5'd20, 6'h00, 5'd1, 5'd2), 32'd3, 32'd4);
        send_word(imm_form(5'd21, 6'h3f, 5'd1, 13'd4), 32'd3, 32'd4);

        // Random: mostly well-formed multiply/divide words, some noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300)
                fork
                    begin
                        // long receiver stall while words keep coming
                        hold_sink = 1'b1;
                        repeat (120) @(negedge clk);
                        hold_sink = 1'b0;
                    end
                join_none
            if (n == RANDOM_WORDS - 150)
                quiet_tail = 1'b1;
            op3 = pick_muldiv();
            case ($urandom_range(0, 9))
                0: w = $urandom;
                1: w = imm_form(5'($urandom), smd_pkg::OP3_FLUSH, 5'($urandom),
                                13'($urandom));
                2: w = {smd_pkg::OP_ARITH, 5'($urandom), op3, 5'($urandom), 1'b0,
                        8'($urandom), 5'($urandom)};
                3, 4, 5: w = imm_form(5'($urandom), op3, 5'($urandom), 13'($urandom));
                default: w = reg_form(5'($urandom), op3, 5'($urandom), 5'($urandom));
            endcase
            send_word(w, pick_operand(), pick_operand());
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (tracker.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (tracker.pending.size() != 0)
            tracker.report_mismatch("result words never arrived",
                                    32'(tracker.pending.size()), 32'd0);
        $display("Sent %0d instruction words, checked %0d results", sent, tracker.checked);
        $display("Outcomes: done %0d, flush %0d, illegal %0d, divide by zero %0d",
                 tracker.status_seen[0], tracker.status_seen[1],
                 tracker.status_seen[2], tracker.status_seen[3]);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hdl/smd_pkg.sv
hdl/smd_ifs.sv
hdl/sparc_mul_div_execute_core.sv
verif/tb_sparc_mul_div_execute_core.sv
